### rtl/core/apdp_pkg.sv
// Shared types and codes for the bit-serial LZ depacker.
`timescale 1ns / 1ps
package apdp_pkg;

  localparam logic [1:0] MODE_BYTE    = 2'd0;
  localparam logic [1:0] MODE_CONT    = 2'd1;
  localparam logic [1:0] MODE_RESTART = 2'd2;

  localparam logic [1:0] ST_NEED_BYTE = 2'd0;
  localparam logic [1:0] ST_NEED_CONT = 2'd1;
  localparam logic [1:0] ST_DONE      = 2'd2;
  localparam logic [1:0] ST_ERROR     = 2'd3;

  typedef enum logic [1:0] {
    KIND_BYTE,
    KIND_CONT,
    KIND_RESTART,
    KIND_NONE
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
  } item_t;

endpackage

### rtl/core/aplib_bit_lz_depacker_unit.sv
// Top level of the bit-serial LZ depacker with its configuration registers.
`timescale 1ns / 1ps
// Usage: the host writes source_length (address 0) and output_capacity
// (address 4) over the APB port while the block is idle. Items enter on the
// in_valid_i/in_ready_o channel with mode_i and src_byte_i; each item yields
// exactly one result on res_valid_o/res_ready_i carrying out_valid_o,
// out_byte_o, status_o, bytes_in_o and bytes_out_o.
// A two-entry queue sits between the front end and the decoder, so items
// are accepted while the decoder works or a result waits to be taken.
// The decoder handles tag bits and byte steps serially, checks each match
// once, and reads each copied byte through the registered history read.
// An item takes in at most one source byte and emits at most one byte.
// The serial tag-bit decoder sets the rate.
// Reset clears the decoder state and the registers; history is not cleared,
// and only bytes written since the last restart are read back.
// When the receiver stalls, the result is held and the decoder stops after
// finishing its current item; the queue then fills and in_ready_o drops.
module aplib_bit_lz_depacker_unit
  import apdp_pkg::*;
#(
  parameter int HISTORY_BYTES = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  mode_i,
  input  logic [7:0]  src_byte_i,
  output logic        res_valid_o,
  input  logic        res_ready_i,
  output logic        out_valid_o,
  output logic [7:0]  out_byte_o,
  output logic [1:0]  status_o,
  output logic [23:0] bytes_in_o,
  output logic [23:0] bytes_out_o
);

  logic [23:0] src_len_q, cap_q;
  logic        item_valid, item_pop;
  item_t       item;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? {8'd0, cap_q} : {8'd0, src_len_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_len_q <= '0;
      cap_q     <= '0;
    end else if (psel && penable && pwrite) begin
      if (paddr[2]) cap_q <= pwdata[23:0];
      else src_len_q <= pwdata[23:0];
    end
  end

  apdp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .mode_i       (mode_i),
    .src_byte_i   (src_byte_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_pop_i   (item_pop)
  );

  apdp_back #(
    .HISTORY_BYTES (HISTORY_BYTES)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .item_valid_i      (item_valid),
    .item_i            (item),
    .item_pop_o        (item_pop),
    .source_length_i   (src_len_q),
    .output_capacity_i (cap_q),
    .res_valid_o       (res_valid_o),
    .res_ready_i       (res_ready_i),
    .out_valid_o       (out_valid_o),
    .out_byte_o        (out_byte_o),
    .status_o          (status_o),
    .bytes_in_o        (bytes_in_o),
    .bytes_out_o       (bytes_out_o)
  );

endmodule

### rtl/core/apdp_ram.sv
// Generic simple dual-port RAM (one write, one read port) with registered read data.
`timescale 1ns / 1ps
module apdp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### rtl/core/apdp_front.sv
// Front end: accepts items, classifies their mode and queues them.
`timescale 1ns / 1ps
module apdp_front
  import apdp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] mode_i,
  input  logic [7:0] src_byte_i,
  output logic       item_valid_o,
  output item_t      item_o,
  input  logic       item_pop_i
);

  item_t       buf_q [2];
  logic        wr_q, rd_q;
  logic [1:0]  cnt_q;
  item_t       item_in;
  logic        push, pop;

  always_comb begin
    item_in.data = src_byte_i;
    unique case (mode_i)
      MODE_BYTE:    item_in.kind = KIND_BYTE;
      MODE_CONT:    item_in.kind = KIND_CONT;
      MODE_RESTART: item_in.kind = KIND_RESTART;
      default:      item_in.kind = KIND_NONE;
    endcase
  end

  assign in_ready_o   = (cnt_q != 2'd2);
  assign item_valid_o = (cnt_q != 2'd0);
  assign item_o       = buf_q[rd_q];
  assign push         = in_valid_i && in_ready_o;
  assign pop          = item_pop_i && item_valid_o;

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_q] <= item_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

### rtl/core/apdp_back.sv
// Back end: serial tag-bit decoder, match copier and result register.
`timescale 1ns / 1ps
module apdp_back
  import apdp_pkg::*;
#(
  parameter int HISTORY_BYTES = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        item_valid_i,
  input  item_t       item_i,
  output logic        item_pop_o,
  input  logic [23:0] source_length_i,
  input  logic [23:0] output_capacity_i,
  output logic        res_valid_o,
  input  logic        res_ready_i,
  output logic        out_valid_o,
  output logic [7:0]  out_byte_o,
  output logic [1:0]  status_o,
  output logic [23:0] bytes_in_o,
  output logic [23:0] bytes_out_o
);

  localparam int AW = $clog2(HISTORY_BYTES);
  localparam logic [AW:0] HSPAN = (AW + 1)'(HISTORY_BYTES);
  localparam logic [AW-1:0] HLAST = AW'(HISTORY_BYTES - 1);
  localparam logic [31:0] HLIM = 32'(HISTORY_BYTES);

  localparam logic [4:0] PH_FIRST = 5'd0;
  localparam logic [4:0] PH_TOP   = 5'd1;
  localparam logic [4:0] PH_LIT   = 5'd2;
  localparam logic [4:0] PH_B1    = 5'd3;
  localparam logic [4:0] PH_B2    = 5'd4;
  localparam logic [4:0] PH_NIB   = 5'd5;
  localparam logic [4:0] PH_SHORT = 5'd6;
  localparam logic [4:0] PH_G1B   = 5'd7;
  localparam logic [4:0] PH_G1C   = 5'd8;
  localparam logic [4:0] PH_OFFB  = 5'd9;
  localparam logic [4:0] PH_G2B   = 5'd10;
  localparam logic [4:0] PH_G2C   = 5'd11;
  localparam logic [4:0] PH_G3B   = 5'd12;
  localparam logic [4:0] PH_G3C   = 5'd13;
  localparam logic [4:0] PH_COPY  = 5'd14;
  localparam logic [4:0] PH_DONE  = 5'd15;
  localparam logic [4:0] PH_ERR   = 5'd16;
  localparam logic [4:0] PH_CHK   = 5'd17;

  logic [4:0]    phase_q, phase_d;
  logic [7:0]    tag_q, tag_d;
  logic [31:0]   last_q, last_d, gam_q, gam_d, off_q, off_d, rem_q, rem_d;
  logic          lost_q, lost_d, want_q, want_d;
  logic [23:0]   icnt_q, icnt_d, ocnt_q, ocnt_d;
  logic [AW-1:0] wp_q, wp_d;
  logic          busy_q, busy_d, fin_q, fin_d, brdy_q, brdy_d, rd_q, rd_d;
  logic [7:0]    byte_q, byte_d, emb_q, emb_d;
  logic          emv_q, emv_d;
  logic          rv_q, rv_d;
  logic          ov_q;
  logic [7:0]    ob_q;
  logic [1:0]    os_q;
  logic [23:0]   oi_q, oo_q;

  logic          tb_need, tb_err, tb_susp, tb_bit, by_err, bit_ok;
  logic [7:0]    tb_tag;
  logic [31:0]   gshift, v32, len32;
  logic [AW:0]   rdiff;
  logic [AW-1:0] raddr;
  logic [7:0]    rdata;
  logic          we, halt, slot_free;
  logic [7:0]    wdata;
  logic [1:0]    status;

  assign tb_need = (tag_q[6:0] == 7'd0);
  assign tb_err  = tb_need && (({1'b0, icnt_q} + 25'd1) >= {1'b0, source_length_i});
  assign tb_susp = tb_need && !brdy_q;
  assign tb_bit  = tb_need ? byte_q[7] : tag_q[7];
  assign tb_tag  = tb_need ? {byte_q[6:0], 1'b1} : {tag_q[6:0], 1'b0};
  assign bit_ok  = !tb_err && !tb_susp;
  assign by_err  = (icnt_q >= source_length_i);
  assign gshift  = {gam_q[30:0], tb_bit};
  assign rdiff   = {1'b0, wp_q} - off_q[AW:0];
  assign raddr   = rdiff[AW] ? AW'(rdiff + HSPAN) : rdiff[AW-1:0];
  assign slot_free = !rv_q || res_ready_i;

  always_comb begin
    if (phase_q == PH_DONE) status = ST_DONE;
    else if (phase_q == PH_ERR) status = ST_ERROR;
    else if (want_q) status = ST_NEED_BYTE;
    else status = ST_NEED_CONT;
  end

  always_comb begin
    phase_d = phase_q; tag_d = tag_q; last_d = last_q; gam_d = gam_q;
    off_d = off_q; rem_d = rem_q; lost_d = lost_q; want_d = want_q;
    icnt_d = icnt_q; ocnt_d = ocnt_q; wp_d = wp_q; busy_d = busy_q;
    fin_d = fin_q; brdy_d = brdy_q; rd_d = rd_q; byte_d = byte_q;
    emb_d = emb_q; emv_d = emv_q;
    item_pop_o = 1'b0; we = 1'b0; wdata = 8'd0; halt = 1'b0;
    v32 = 32'd0; len32 = 32'd0;

    if (fin_q) begin
      if (slot_free) fin_d = 1'b0;
    end else if (!busy_q) begin
      if (item_valid_i) begin
        item_pop_o = 1'b1;
        emv_d = 1'b0;
        emb_d = 8'd0;
        fin_d = 1'b1;
        if (item_i.kind == KIND_RESTART) begin
          phase_d = PH_FIRST; tag_d = 8'h80; last_d = '0; gam_d = '0;
          off_d = '0; rem_d = '0; lost_d = 1'b1; want_d = 1'b1;
          icnt_d = '0; ocnt_d = '0; wp_d = '0; brdy_d = 1'b0; rd_d = 1'b0;
        end else if (phase_q != PH_DONE && phase_q != PH_ERR) begin
          if (item_i.kind == KIND_BYTE && want_q) begin
            brdy_d = 1'b1; byte_d = item_i.data; want_d = 1'b0;
            busy_d = 1'b1; fin_d = 1'b0;
          end else if (item_i.kind == KIND_CONT && !want_q) begin
            busy_d = 1'b1; fin_d = 1'b0;
          end
        end
      end
    end else begin
      unique case (phase_q)
        PH_FIRST, PH_LIT, PH_SHORT, PH_OFFB: begin
          if (phase_q == PH_FIRST &&
              (source_length_i == 24'd0 || output_capacity_i == 24'd0)) begin
            phase_d = PH_ERR; halt = 1'b1;
          end else if (phase_q == PH_LIT && ocnt_q >= output_capacity_i) begin
            phase_d = PH_ERR; halt = 1'b1;
          end else if (by_err) begin
            phase_d = PH_ERR; halt = 1'b1;
          end else if (!brdy_q) begin
            want_d = 1'b1; halt = 1'b1;
          end else begin
            brdy_d = 1'b0;
            icnt_d = icnt_q + 24'd1;
            if (phase_q == PH_FIRST || phase_q == PH_LIT) begin
              halt = 1'b1;
              if (ocnt_q >= output_capacity_i) begin
                phase_d = PH_ERR;
              end else begin
                we = 1'b1; wdata = byte_q; emv_d = 1'b1; emb_d = byte_q;
                ocnt_d = ocnt_q + 24'd1;
                wp_d = (wp_q == HLAST) ? '0 : wp_q + AW'(1);
                phase_d = PH_TOP;
                if (phase_q == PH_LIT) lost_d = 1'b1;
              end
            end else if (phase_q == PH_SHORT) begin
              v32 = {25'd0, byte_q[7:1]};
              if (v32 == 32'd0) begin
                phase_d = PH_DONE; halt = 1'b1;
              end else begin
                last_d = v32; lost_d = 1'b0; off_d = v32;
                rem_d = {30'd0, 1'b1, byte_q[0]};
                phase_d = PH_CHK;
              end
            end else begin
              off_d = off_q + {24'd0, byte_q};
              gam_d = 32'd1;
              phase_d = PH_G3B;
            end
          end
        end
        PH_CHK: begin
          if (off_q == 32'd0 || off_q > {8'd0, ocnt_q} || off_q > HLIM ||
              ({9'd0, ocnt_q} + {1'b0, rem_q}) > {9'd0, output_capacity_i}) begin
            phase_d = PH_ERR; halt = 1'b1;
          end else if (rem_q == 32'd0) begin
            phase_d = PH_TOP;
          end else begin
            phase_d = PH_COPY;
          end
        end
        PH_COPY: begin
          if (!rd_q) begin
            rd_d = 1'b1;
          end else begin
            rd_d = 1'b0;
            halt = 1'b1;
            if (ocnt_q >= output_capacity_i) begin
              phase_d = PH_ERR;
            end else begin
              we = 1'b1; wdata = rdata; emv_d = 1'b1; emb_d = rdata;
              ocnt_d = ocnt_q + 24'd1;
              wp_d = (wp_q == HLAST) ? '0 : wp_q + AW'(1);
              rem_d = rem_q - 32'd1;
              if (rem_q == 32'd1) phase_d = PH_TOP;
            end
          end
        end
        PH_DONE, PH_ERR: begin
          halt = 1'b1;
        end
        default: begin
          if (tb_err) begin
            phase_d = PH_ERR; halt = 1'b1;
          end else if (tb_susp) begin
            want_d = 1'b1; halt = 1'b1;
          end else begin
            tag_d = tb_tag;
            if (tb_need) begin
              brdy_d = 1'b0;
              icnt_d = icnt_q + 24'd1;
            end
            case (phase_q)
              PH_TOP: phase_d = tb_bit ? PH_B1 : PH_LIT;
              PH_B1: begin
                if (tb_bit) phase_d = PH_B2;
                else begin gam_d = 32'd1; phase_d = PH_G1B; end
              end
              PH_B2: begin
                if (tb_bit) begin
                  lost_d = 1'b1; gam_d = 32'h10; phase_d = PH_NIB;
                end else phase_d = PH_SHORT;
              end
              PH_NIB: begin
                gam_d = gshift;
                if (gshift >= 32'h100) begin
                  if (gshift[7:0] == 8'd0) begin
                    halt = 1'b1;
                    if (ocnt_q >= output_capacity_i) begin
                      phase_d = PH_ERR;
                    end else begin
                      we = 1'b1; wdata = 8'd0; emv_d = 1'b1; emb_d = 8'd0;
                      ocnt_d = ocnt_q + 24'd1;
                      wp_d = (wp_q == HLAST) ? '0 : wp_q + AW'(1);
                      phase_d = PH_TOP;
                    end
                  end else begin
                    off_d = {24'd0, gshift[7:0]}; rem_d = 32'd1; phase_d = PH_CHK;
                  end
                end
              end
              PH_G1B, PH_G2B, PH_G3B: begin
                gam_d = gshift;
                phase_d = phase_q + 5'd1;
              end
              PH_G1C: begin
                if (tb_bit) phase_d = PH_G1B;
                else begin
                  v32 = gam_q - 32'd1 - {31'd0, lost_q};
                  if (v32 == 32'd0) begin
                    gam_d = 32'd1; phase_d = PH_G2B;
                  end else begin
                    off_d = {v32[23:0] - 24'd1, 8'd0}; phase_d = PH_OFFB;
                  end
                end
              end
              PH_G2C: begin
                if (tb_bit) phase_d = PH_G2B;
                else begin
                  lost_d = 1'b0; off_d = last_q; rem_d = gam_q; phase_d = PH_CHK;
                end
              end
              PH_G3C: begin
                if (tb_bit) phase_d = PH_G3B;
                else begin
                  len32 = gam_q;
                  if (off_q >= 32'h7d00) len32 = len32 + 32'd1;
                  if (off_q >= 32'h500) len32 = len32 + 32'd1;
                  if (off_q <= 32'h7f) len32 = len32 + 32'd2;
                  last_d = off_q; lost_d = 1'b0; rem_d = len32; phase_d = PH_CHK;
                end
              end
              default: begin
                phase_d = PH_ERR; halt = 1'b1;
              end
            endcase
          end
        end
      endcase
      if (halt) begin
        busy_d = 1'b0;
        fin_d = 1'b1;
        rd_d = 1'b0;
      end
    end
  end

  assign rv_d = (fin_q && slot_free) ? 1'b1 : (res_ready_i ? 1'b0 : rv_q);

  apdp_ram #(
    .WIDTH (8),
    .DEPTH (HISTORY_BYTES)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (wp_q),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_FIRST; tag_q <= 8'h80; last_q <= '0; gam_q <= '0;
      off_q <= '0; rem_q <= '0; lost_q <= 1'b1; want_q <= 1'b1;
      icnt_q <= '0; ocnt_q <= '0; wp_q <= '0; busy_q <= 1'b0;
      fin_q <= 1'b0; brdy_q <= 1'b0; rd_q <= 1'b0; rv_q <= 1'b0;
      emv_q <= 1'b0;
    end else begin
      phase_q <= phase_d; tag_q <= tag_d; last_q <= last_d; gam_q <= gam_d;
      off_q <= off_d; rem_q <= rem_d; lost_q <= lost_d; want_q <= want_d;
      icnt_q <= icnt_d; ocnt_q <= ocnt_d; wp_q <= wp_d; busy_q <= busy_d;
      fin_q <= fin_d; brdy_q <= brdy_d; rd_q <= rd_d; rv_q <= rv_d;
      emv_q <= emv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    emb_q  <= emb_d;
    if (fin_q && slot_free) begin
      ov_q <= emv_q;
      ob_q <= emv_q ? emb_q : 8'd0;
      os_q <= status;
      oi_q <= icnt_q;
      oo_q <= ocnt_q;
    end
  end

  assign res_valid_o = rv_q;
  assign out_valid_o = ov_q;
  assign out_byte_o  = ob_q;
  assign status_o    = os_q;
  assign bytes_in_o  = oi_q;
  assign bytes_out_o = oo_q;

`ifndef SYNTH
  a_fin_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_q |-> !busy_q) else $error("Result pending while an item is still running.");
  a_emit_no_want: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fin_q && emv_q) |-> !want_q) else $error("Emitted byte while waiting for a byte.");
  a_read_in_copy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_q |-> (phase_q == PH_COPY && busy_q)) else $error("History read outside a copy.");
  a_write_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |=> (ocnt_q == $past(ocnt_q) + 24'd1)) else $error("History write without count.");
`endif

endmodule

### sim/aplib_bit_lz_depacker_checker.sv
// Checker that predicts and compares every result of the bit-serial LZ depacker.
`timescale 1ns / 1ps
module aplib_bit_lz_depacker_checker
  import apdp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  input  logic        in_valid_i,
  input  logic        in_ready_o,
  input  logic [1:0]  mode_i,
  input  logic [7:0]  src_byte_i,
  input  logic        res_valid_o,
  input  logic        res_ready_i,
  input  logic        out_valid_o,
  input  logic [7:0]  out_byte_o,
  input  logic [1:0]  status_o,
  input  logic [23:0] bytes_in_o,
  input  logic [23:0] bytes_out_o,
  output int          fail_count_o,
  output int          pending_o
);

  localparam int unsigned WINDOW = 65536;
  localparam logic [2:0] ADDR_SRC_LEN = 3'd0;
  localparam logic [2:0] ADDR_OUT_CAP = 3'd4;

  typedef enum logic [4:0] {
    DEC_FIRST, DEC_TOP, DEC_LIT, DEC_B1, DEC_B2, DEC_NIB, DEC_SHORT,
    DEC_G1B, DEC_G1C, DEC_OFFB, DEC_G2B, DEC_G2C, DEC_G3B, DEC_G3C,
    DEC_COPY, DEC_DONE, DEC_ERR
  } dec_phase_e;

  typedef struct {
    logic        valid;
    logic [7:0]  data;
    logic [1:0]  status;
    logic [23:0] bytes_in;
    logic [23:0] bytes_out;
  } depack_result_s;

  depack_result_s expected_results[$];
  logic [7:0]  window_mem [0:WINDOW-1];
  logic [7:0]  tag_reg;
  int unsigned last_off, lost, gacc, match_off, match_left, in_cnt, out_cnt;
  int unsigned src_len, out_cap;
  dec_phase_e  ph;
  logic        want_byte, have_byte, did_emit;
  logic [7:0]  byte_val, emit_byte;
  int          fails;

  assign fail_count_o = fails;
  assign pending_o = expected_results.size();

  function automatic void decoder_restart();
    tag_reg = 8'h80;
    last_off = 0;
    lost = 1;
    ph = DEC_FIRST;
    gacc = 0;
    match_off = 0;
    match_left = 0;
    in_cnt = 0;
    out_cnt = 0;
    want_byte = 1'b1;
  endfunction

  function automatic int next_tag_bit();
    logic b;
    if (tag_reg[6:0] == 7'd0) begin
      if (in_cnt + 1 >= src_len) begin
        ph = DEC_ERR;
        return -1;
      end
      if (!have_byte) begin
        want_byte = 1'b1;
        return -1;
      end
      have_byte = 1'b0;
      in_cnt++;
      tag_reg = {byte_val[6:0], 1'b1};
      return int'(byte_val[7]);
    end
    b = tag_reg[7];
    tag_reg = {tag_reg[6:0], 1'b0};
    return int'(b);
  endfunction

  function automatic int next_src_byte();
    if (in_cnt >= src_len) begin
      ph = DEC_ERR;
      return -1;
    end
    if (!have_byte) begin
      want_byte = 1'b1;
      return -1;
    end
    have_byte = 1'b0;
    in_cnt++;
    return int'(byte_val);
  endfunction

  function automatic bit put_out(logic [7:0] v);
    if (out_cnt >= out_cap) begin
      ph = DEC_ERR;
      return 1'b0;
    end
    window_mem[out_cnt % WINDOW] = v;
    out_cnt++;
    did_emit = 1'b1;
    emit_byte = v;
    return 1'b1;
  endfunction

  function automatic void begin_match(int unsigned off, int unsigned len);
    if (off == 0 || off > out_cnt || off > WINDOW ||
        longint'(out_cnt) + longint'(len) > longint'(out_cap)) begin
      ph = DEC_ERR;
      return;
    end
    if (len == 0) begin
      ph = DEC_TOP;
      return;
    end
    match_off = off;
    match_left = len;
    ph = DEC_COPY;
  endfunction

  function automatic void run_decoder();
    int r;
    int unsigned v, len;
    while (!did_emit && ph != DEC_DONE && ph != DEC_ERR) begin
      case (ph)
        DEC_FIRST: begin
          if (src_len == 0 || out_cap == 0) begin
            ph = DEC_ERR;
            return;
          end
          r = next_src_byte();
          if (r < 0) return;
          if (!put_out(r[7:0])) return;
          ph = DEC_TOP;
        end
        DEC_TOP: begin
          r = next_tag_bit();
          if (r < 0) return;
          ph = r ? DEC_B1 : DEC_LIT;
        end
        DEC_LIT: begin
          if (out_cnt >= out_cap) begin
            ph = DEC_ERR;
            return;
          end
          r = next_src_byte();
          if (r < 0) return;
          if (!put_out(r[7:0])) return;
          lost = 1;
          ph = DEC_TOP;
        end
        DEC_B1: begin
          r = next_tag_bit();
          if (r < 0) return;
          if (r) ph = DEC_B2;
          else begin
            gacc = 1;
            ph = DEC_G1B;
          end
        end
        DEC_B2: begin
          r = next_tag_bit();
          if (r < 0) return;
          if (r) begin
            lost = 1;
            gacc = 32'h10;
            ph = DEC_NIB;
          end else ph = DEC_SHORT;
        end
        DEC_NIB: begin
          r = next_tag_bit();
          if (r < 0) return;
          gacc = gacc * 2 + r;
          if (gacc >= 32'h100) begin
            v = gacc & 32'hff;
            if (v == 0) begin
              if (!put_out(8'h00)) return;
              ph = DEC_TOP;
            end else begin_match(v, 1);
          end
        end
        DEC_SHORT: begin
          r = next_src_byte();
          if (r < 0) return;
          v = r >> 1;
          if (v == 0) begin
            ph = DEC_DONE;
            return;
          end
          len = (r & 1) + 2;
          last_off = v;
          lost = 0;
          begin_match(v, len);
        end
        DEC_G1B, DEC_G2B, DEC_G3B: begin
          r = next_tag_bit();
          if (r < 0) return;
          gacc = gacc * 2 + r;
          ph = dec_phase_e'(ph + 1);
        end
        DEC_G1C: begin
          r = next_tag_bit();
          if (r < 0) return;
          if (r) ph = DEC_G1B;
          else begin
            v = gacc - 1 - lost;
            if (v == 0) begin
              gacc = 1;
              ph = DEC_G2B;
            end else begin
              match_off = (v - 1) << 8;
              ph = DEC_OFFB;
            end
          end
        end
        DEC_OFFB: begin
          r = next_src_byte();
          if (r < 0) return;
          match_off += r;
          gacc = 1;
          ph = DEC_G3B;
        end
        DEC_G2C: begin
          r = next_tag_bit();
          if (r < 0) return;
          if (r) ph = DEC_G2B;
          else begin
            lost = 0;
            begin_match(last_off, gacc);
          end
        end
        DEC_G3C: begin
          r = next_tag_bit();
          if (r < 0) return;
          if (r) ph = DEC_G3B;
          else begin
            len = gacc;
            v = match_off;
            if (v >= 32'h7d00) len++;
            if (v >= 32'h500) len++;
            if (v <= 32'h7f) len += 2;
            last_off = v;
            lost = 0;
            begin_match(v, len);
          end
        end
        DEC_COPY: begin
          v = (out_cnt - match_off) % WINDOW;
          if (!put_out(window_mem[v])) return;
          match_left--;
          if (match_left == 0) ph = DEC_TOP;
        end
        default: begin
          ph = DEC_ERR;
          return;
        end
      endcase
    end
  endfunction

  function automatic depack_result_s predict_depack(logic [1:0] mode, logic [7:0] data);
    depack_result_s res;
    did_emit = 1'b0;
    emit_byte = 8'h00;
    have_byte = 1'b0;
    if (mode == MODE_RESTART) decoder_restart();
    else if (ph != DEC_DONE && ph != DEC_ERR) begin
      if (mode == MODE_BYTE && want_byte) begin
        have_byte = 1'b1;
        byte_val = data;
        want_byte = 1'b0;
        run_decoder();
      end else if (mode == MODE_CONT && !want_byte) begin
        run_decoder();
      end
    end
    have_byte = 1'b0;
    res.valid = did_emit;
    res.data = did_emit ? emit_byte : 8'h00;
    if (ph == DEC_DONE) res.status = ST_DONE;
    else if (ph == DEC_ERR) res.status = ST_ERROR;
    else if (want_byte) res.status = ST_NEED_BYTE;
    else res.status = ST_NEED_CONT;
    res.bytes_in = in_cnt[23:0];
    res.bytes_out = out_cnt[23:0];
    return res;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("%0t: mismatch in %s: got 0x%0h, expected 0x%0h", $time, field, got, want);
    fails++;
  endtask

  initial begin
    fails = 0;
    src_len = 0;
    out_cap = 0;
    decoder_restart();
  end

  always @(posedge clk_i) begin
    depack_result_s want;
    if (!rst_ni) begin
      src_len = 0;
      out_cap = 0;
      decoder_restart();
      expected_results.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == ADDR_SRC_LEN) src_len = pwdata[23:0];
        else if (paddr == ADDR_OUT_CAP) out_cap = pwdata[23:0];
      end
      if (in_valid_i && in_ready_o)
        expected_results.push_back(predict_depack(mode_i, src_byte_i));
      if (res_valid_o && res_ready_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result arrived with no item outstanding", $time);
          fails++;
        end else begin
          want = expected_results.pop_front();
          if (out_valid_o !== want.valid) report_mismatch("out_valid", out_valid_o, want.valid);
          if (out_byte_o !== want.data) report_mismatch("out_byte", out_byte_o, want.data);
          if (status_o !== want.status) report_mismatch("status", status_o, want.status);
          if (bytes_in_o !== want.bytes_in)
            report_mismatch("bytes_in", bytes_in_o, want.bytes_in);
          if (bytes_out_o !== want.bytes_out)
            report_mismatch("bytes_out", bytes_out_o, want.bytes_out);
        end
      end
    end
  end

endmodule

### sim/aplib_bit_lz_depacker_unit_test.sv
// Testbench top that feeds encoded streams and noise to the LZ depacker.
`timescale 1ns / 1ps
module aplib_bit_lz_depacker_unit_test;
  import apdp_pkg::*;

  localparam logic [2:0] ADDR_SRC_LEN = 3'd0;
  localparam logic [2:0] ADDR_OUT_CAP = 3'd4;
  localparam int CYCLE_LIMIT = 600000;

  logic        clk_i, rst_ni;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;
  logic        in_valid_i, in_ready_o;
  logic [1:0]  mode_i;
  logic [7:0]  src_byte_i;
  logic        res_valid_o, res_ready_i;
  logic        out_valid_o;
  logic [7:0]  out_byte_o;
  logic [1:0]  status_o;
  logic [23:0] bytes_in_o, bytes_out_o;
  int          fail_count, pending;

  logic [7:0]  packed_stream[$];
  int          tag_pos, tag_left, produced, prev_off, lost_flag;
  int          items_sent, cycles, stall_left;
  logic [1:0]  last_status;
  bit          quiet;

  aplib_bit_lz_depacker_unit dut (.*);

  aplib_bit_lz_depacker_checker checker_i (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .in_valid_i, .in_ready_o, .mode_i, .src_byte_i, .res_valid_o, .res_ready_i,
    .out_valid_o, .out_byte_o, .status_o, .bytes_in_o, .bytes_out_o,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      res_ready_i <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 10);
      res_ready_i <= 1'b0;
    end else begin
      res_ready_i <= 1'b1;
    end
  end

  task automatic reg_write(logic [2:0] addr, logic [31:0] data);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic send_item(logic [1:0] mode, logic [7:0] data);
    in_valid_i <= 1'b1;
    mode_i <= mode;
    src_byte_i <= data;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  task automatic sender_gap();
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
  endtask

  // Sends one item and waits for its result before returning.
  task automatic step_item(logic [1:0] mode, logic [7:0] data);
    sender_gap();
    send_item(mode, data);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (!(res_valid_o && res_ready_i));
    last_status = status_o;
  endtask

  function automatic void put_bit(int b);
    if (tag_left == 0) begin
      tag_pos = packed_stream.size();
      packed_stream.push_back(8'h00);
      tag_left = 8;
    end
    tag_left--;
    if (b != 0) packed_stream[tag_pos][tag_left] = 1'b1;
  endfunction

  function automatic void put_gamma(int unsigned v);
    int msb;
    msb = 31;
    while (!v[msb]) msb--;
    for (int i = msb - 1; i >= 0; i--) begin
      put_bit(v[i]);
      put_bit(i > 0);
    end
  endfunction

  // Builds literals, zero bytes and matches; sound unless bad_offset.
  function automatic void encode_stream(int tokens, bit bad_offset);
    int kind, off, len, glen, adj;
    packed_stream.delete();
    tag_left = 0;
    produced = 1;
    prev_off = 0;
    lost_flag = 1;
    packed_stream.push_back(8'($urandom));
    for (int t = 0; t < tokens; t++) begin
      kind = $urandom_range(0, 5);
      if (kind == 5 && !(lost_flag == 1 && prev_off > 0)) kind = 0;
      case (kind)
        0, 1: begin
          put_bit(0);
          packed_stream.push_back(8'($urandom));
          lost_flag = 1;
          produced++;
        end
        2: begin
          put_bit(1); put_bit(1); put_bit(1);
          off = $urandom_range(0, produced < 15 ? produced : 15);
          if ($urandom_range(0, 3) == 0) off = 0;
          for (int i = 3; i >= 0; i--) put_bit(off[i]);
          lost_flag = 1;
          produced++;
        end
        3: begin
          put_bit(1); put_bit(1); put_bit(0);
          off = $urandom_range(1, produced < 127 ? produced : 127);
          if (bad_offset && produced < 127) off = produced + 1;
          len = $urandom_range(2, 3);
          packed_stream.push_back(8'((off << 1) | (len - 2)));
          prev_off = off;
          lost_flag = 0;
          produced += len;
        end
        4: begin
          put_bit(1); put_bit(0);
          off = $urandom_range(1, produced);
          put_gamma((off >> 8) + 2 + lost_flag);
          packed_stream.push_back(8'(off));
          glen = $urandom_range(2, 6);
          put_gamma(glen);
          adj = off <= 32'h7f ? 2 : 0;
          prev_off = off;
          lost_flag = 0;
          produced += glen + adj;
        end
        default: begin
          put_bit(1); put_bit(0);
          put_gamma(2);
          glen = $urandom_range(2, 5);
          put_gamma(glen);
          lost_flag = 0;
          produced += glen;
        end
      endcase
    end
    put_bit(1); put_bit(1); put_bit(0);
    packed_stream.push_back(8'h00);
  endfunction

  task automatic run_stream(int tokens);
    int pos, guard, sel;
    logic [31:0] slen, ocap;
    encode_stream(tokens, $urandom_range(0, 9) == 0);
    slen = packed_stream.size();
    ocap = produced;
    sel = $urandom_range(0, 9);
    if (sel == 0) slen = $urandom_range(1, packed_stream.size());
    else if (sel == 1) ocap = $urandom_range(1, produced);
    else if (sel == 2) ocap = 32'hffffff;
    else if (sel == 3) slen = 32'hffffff;
    reg_write(ADDR_SRC_LEN, slen);
    reg_write(ADDR_OUT_CAP, ocap);
    step_item(MODE_RESTART, 8'($urandom));
    pos = 0;
    guard = 0;
    while (last_status != ST_DONE && last_status != ST_ERROR && guard < 600) begin
      guard++;
      if ($urandom_range(0, 24) == 0) step_item(2'($urandom_range(0, 3)), 8'($urandom));
      else if (last_status == ST_NEED_BYTE) begin
        step_item(MODE_BYTE, pos < packed_stream.size() ? packed_stream[pos] : 8'($urandom));
        pos++;
      end else step_item(MODE_CONT, 8'($urandom));
    end
    if ($urandom_range(0, 1) == 0) step_item(MODE_CONT, 8'($urandom));
  endtask

  initial begin
    cycles = 0;
    stall_left = 0;
    quiet = 1'b0;
    items_sent = 0;
    rst_ni <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= ADDR_SRC_LEN;
    pwdata <= 32'h0;
    in_valid_i <= 1'b0;
    mode_i <= MODE_CONT;
    src_byte_i <= 8'h00;
    res_ready_i <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Zero registers, ignored modes and mismatched items.
    step_item(MODE_BYTE, 8'hff);
    step_item(MODE_BYTE, 8'h00);
    step_item(MODE_RESTART, 8'h00);
    reg_write(ADDR_SRC_LEN, 32'hffffff);
    step_item(MODE_BYTE, 8'h5a);
    step_item(MODE_RESTART, 8'hff);
    reg_write(ADDR_OUT_CAP, 32'hffffff);
    step_item(2'd3, 8'h12);
    step_item(MODE_CONT, 8'h34);
    step_item(MODE_BYTE, 8'h80);
    step_item(MODE_BYTE, 8'h7f);
    step_item(MODE_BYTE, 8'hff);
    step_item(MODE_CONT, 8'h00);
    step_item(MODE_CONT, 8'hff);
    step_item(MODE_RESTART, 8'h00);
    reg_write(ADDR_SRC_LEN, 32'd1);
    step_item(MODE_BYTE, 8'h01);
    step_item(MODE_CONT, 8'h00);
    step_item(MODE_RESTART, 8'h00);
    reg_write(ADDR_SRC_LEN, 32'd0);
    step_item(MODE_BYTE, 8'h01);

    run_stream(0);
    while (items_sent < 800) run_stream($urandom_range(1, 30));

    // Back-to-back noise with no idling at the end.
    reg_write(ADDR_SRC_LEN, 32'hffffff);
    reg_write(ADDR_OUT_CAP, 32'hffffff);
    quiet = 1'b1;
    repeat (100) begin
      if ($urandom_range(0, 19) == 0) send_item(MODE_RESTART, 8'($urandom));
      else send_item(2'($urandom_range(0, 1)), 8'($urandom));
    end
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (fail_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

### filelist.f
rtl/core/apdp_pkg.sv
rtl/core/apdp_ram.sv
rtl/core/apdp_front.sv
rtl/core/apdp_back.sv
rtl/core/aplib_bit_lz_depacker_unit.sv
sim/aplib_bit_lz_depacker_checker.sv
sim/aplib_bit_lz_depacker_unit_test.sv
